FILE: hw/rtl/rtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_pkg
// Types and constants shared by the radix integer text parser.
// ----------------------------------------------------------------------------
package rtp_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int COUNT_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;
	localparam int ADDR_BITS      = 3;

	localparam logic [5:0] DIGIT_ZERO = 6'd0;
	localparam logic [5:0] DIGIT_X    = 6'd33;
	localparam logic [5:0] DIGIT_NONE = 6'd63;
	localparam logic [5:0] RADIX_AUTO = 6'd0;
	localparam logic [5:0] RADIX_OCT  = 6'd8;
	localparam logic [5:0] RADIX_DEC  = 6'd10;
	localparam logic [5:0] RADIX_HEX  = 6'd16;
	localparam logic [5:0] RADIX_MAX  = 6'd36;

	localparam logic REG_BASE = 1'b0;

	typedef struct packed {
		logic [7:0] char_code;
		logic       first_char;
	} item_t;

	typedef struct packed {
		logic [63:0] parsed_value;
		logic [15:0] chars_consumed;
		logic [5:0]  radix_used;
	} result_t;

	typedef struct packed {
		logic       first;
		logic [5:0] digit;
		logic [5:0] base;
	} cls_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_DIGITS = 3'b010,
		PH_ZERO   = 3'b100
	} phase_t;

endpackage

FILE: hw/rtl/rtp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_fifo
// Short register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module rtp_fifo import rtp_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

endmodule

FILE: hw/rtl/rtp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_front
// Character classifier: digit value of each character and the clamped base.
// ----------------------------------------------------------------------------
module rtp_front import rtp_pkg::*; (
	input  item_t      item,
	input  logic [5:0] base_setting,
	output cls_t       cls
);

	logic [7:0] lower;

	always_comb begin
		lower = item.char_code;
		if (item.char_code >= "A" && item.char_code <= "Z") begin
			lower = item.char_code + 8'd32;
		end

		cls.first = item.first_char;
		if (lower >= "0" && lower <= "9") begin
			cls.digit = 6'(lower - "0");
		end else if (lower >= "a" && lower <= "z") begin
			cls.digit = 6'(lower - "a") + 6'd10;
		end else begin
			cls.digit = DIGIT_NONE;
		end

		// clamp
		cls.base = (base_setting > RADIX_MAX) ? RADIX_MAX : base_setting;
	end

endmodule

FILE: hw/rtl/rtp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_back
// Parse sequencer: prefix handling, multiply-add accumulation, result issue.
// ----------------------------------------------------------------------------
module rtp_back import rtp_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  cls_t    cls,
	input  logic    cls_valid,
	output logic    cls_pop,
	input  logic    res_full,
	output logic    res_push,
	output result_t res
);

	phase_t                phase_q;
	phase_t                phase_d;
	logic [VALUE_BITS-1:0] acc_q;
	logic [VALUE_BITS-1:0] acc_d;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] cnt_d;
	logic [5:0]            rad_q;
	logic [5:0]            rad_d;
	logic [VALUE_BITS-1:0] acc_in;
	logic [COUNT_BITS-1:0] cnt_in;
	logic [5:0]            rad_in;
	logic [VALUE_BITS-1:0] mac;
	logic                  take;
	logic                  emit;

	assign cls_pop  = cls_valid && !res_full;
	assign res_push = cls_pop && emit;

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		rad_d   = rad_q;
		acc_in  = acc_q;
		cnt_in  = cnt_q;
		rad_in  = rad_q;
		take    = 1'b0;
		emit    = 1'b0;
		mac     = '0;

		if (cls.first) begin
			acc_in = '0;
			cnt_in = '0;
			rad_in = (cls.base == RADIX_AUTO) ? RADIX_DEC : cls.base;
			if (cls.digit == DIGIT_ZERO) begin
				acc_d   = '0;
				cnt_d   = COUNT_BITS'(1);
				rad_d   = cls.base;
				phase_d = PH_ZERO;
			end else begin
				take = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_ZERO: begin
					if (cls.digit == DIGIT_X) begin
						acc_d   = '0;
						cnt_d   = COUNT_BITS'(2);
						rad_d   = RADIX_HEX;
						phase_d = PH_DIGITS;
					end else begin
						rad_in = (rad_q == RADIX_AUTO) ? RADIX_OCT : rad_q;
						take   = 1'b1;
					end
				end
				PH_DIGITS: begin
					take = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		if (take) begin
			rad_d = rad_in;
			mac   = VALUE_BITS'(acc_in * VALUE_BITS'(rad_in)) + VALUE_BITS'(cls.digit);
			if (cls.digit < rad_in) begin
				acc_d   = mac;
				cnt_d   = (cnt_in == '1) ? cnt_in : cnt_in + COUNT_BITS'(1);
				phase_d = PH_DIGITS;
			end else begin
				acc_d   = acc_in;
				cnt_d   = cnt_in;
				emit    = 1'b1;
				phase_d = PH_IDLE;
			end
		end

		res.parsed_value   = 64'(acc_in);
		res.chars_consumed = 16'(cnt_in);
		res.radix_used     = rad_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (cls_pop) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cls_pop) begin
			acc_q <= acc_d;
			cnt_q <= cnt_d;
			rad_q <= rad_d;
		end
	end

endmodule

FILE: hw/rtl/radix_integer_text_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_integer_text_parser
// Streaming unsigned integer parser with automatic 0x / leading-zero radix.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  input     push / full         item   (char_code, first_char)
//  result    pop / empty         result (parsed_value, chars_consumed, radix_used)
//  config    APB psel/penable    base_setting at byte address 0
//
//  One character per cycle while the result queue has room; the multiply-add of
//  the accumulator by the radix sets that figure. A result is visible once through
//  both queues. Full rises only when both queues back up behind a stalled pop.
//  Reset clears the parse phase, queues and base_setting; no clearing pass.
// ----------------------------------------------------------------------------
module radix_integer_text_parser import rtp_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  item_t                item,
	output logic                 full,
	input  logic                 pop,
	output result_t              result,
	output logic                 empty,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic [5:0] base_q;
	cls_t       cls_front;
	cls_t       cls_back;
	logic       mid_empty;
	logic       mid_pop;
	logic       res_full;
	logic       res_push;
	result_t    res_back;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BASE) ? {26'd0, base_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= RADIX_AUTO;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_BASE) begin
			base_q <= pwdata[5:0];
		end
	end

	rtp_front u_front (
		.item         (item),
		.base_setting (base_q),
		.cls          (cls_front)
	);

	rtp_fifo #(
		.WIDTH ($bits(cls_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls_front),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (cls_back),
		.empty  (mid_empty)
	);

	rtp_back #(
		.VALUE_BITS (VALUE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls       (cls_back),
		.cls_valid (!mid_empty),
		.cls_pop   (mid_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_back)
	);

	rtp_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_back),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written into a full queue");

	a_mid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && mid_empty |=> !mid_empty)
		else $error("accepted character lost before the parser");

	a_radix_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.radix_used != 6'd0) && (result.radix_used <= RADIX_MAX))
		else $error("result radix out of range");

endmodule

FILE: dv/radix_integer_text_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_integer_text_parser_tb
// Self-checking bench for the streaming unsigned integer parser. A directed
// table covers prefixes, radix limits and dropped strings. Random strings
// follow under a sweep of base settings, after one long decimal string that
// wraps the value. Each result transfer is checked against its table row's
// expected result or a model of the parse. Both queue sides idle at random.
// ----------------------------------------------------------------------------
module radix_integer_text_parser_tb;
	import rtp_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 86;
	localparam int LONG_DIGITS   = 30;
	localparam int DIR_ROWS      = 27;
	localparam logic [ADDR_BITS-1:0] BASE_ADDR = ADDR_BITS'(REG_BASE) << 2;

	typedef struct packed {
		logic [5:0] base;
		logic [7:0] ch;
		logic       first_char;
		logic       typed;
		result_t    want;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	item_t                item = '0;
	logic                 full;
	logic                 pop = 1'b0;
	result_t              result;
	logic                 empty;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;

	radix_integer_text_parser uut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .item(item), .full(full),
		.pop(pop), .result(result), .empty(empty),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// parser model state
	phase_t      model_phase = PH_IDLE;
	logic [63:0] model_acc = '0;
	logic [15:0] model_count = '0;
	logic [5:0]  model_radix = '0;
	logic [5:0]  model_base = '0;

	result_t     pending_results [$];
	int unsigned mismatches = 0;
	int unsigned pops_done = 0;
	int unsigned cycle_count = 0;
	logic        typed_on = 1'b0;
	result_t     typed_want = '0;
	logic        calm = 1'b0;
	logic [5:0]  cur_base = RADIX_AUTO;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{RADIX_AUTO, "Q",   1'b0, 1'b0, '0},
		'{RADIX_AUTO, "0",   1'b1, 1'b0, '0},
		'{RADIX_AUTO, "x",   1'b0, 1'b0, '0},
		'{RADIX_AUTO, "F",   1'b0, 1'b0, '0},
		'{RADIX_AUTO, ";",   1'b0, 1'b1, '{64'd15, 16'd3, RADIX_HEX}},
		'{RADIX_AUTO, "0",   1'b1, 1'b0, '0},
		'{RADIX_AUTO, "7",   1'b0, 1'b0, '0},
		'{RADIX_AUTO, " ",   1'b0, 1'b1, '{64'd7, 16'd2, RADIX_OCT}},
		'{RADIX_AUTO, "0",   1'b1, 1'b0, '0},
		'{RADIX_AUTO, ";",   1'b0, 1'b1, '{64'd0, 16'd1, RADIX_OCT}},
		'{RADIX_AUTO, "0",   1'b1, 1'b0, '0},
		'{RADIX_AUTO, "X",   1'b0, 1'b0, '0},
		'{RADIX_AUTO, "/",   1'b0, 1'b1, '{64'd0, 16'd2, RADIX_HEX}},
		'{RADIX_AUTO, "+",   1'b1, 1'b1, '{64'd0, 16'd0, RADIX_DEC}},
		'{RADIX_AUTO, "9",   1'b1, 1'b0, '0},
		'{RADIX_AUTO, "5",   1'b1, 1'b0, '0},
		'{RADIX_AUTO, 8'hFF, 1'b0, 1'b1, '{64'd5, 16'd1, RADIX_DEC}},
		'{6'd63,      "z",   1'b1, 1'b0, '0},
		'{6'd63,      "Z",   1'b0, 1'b0, '0},
		'{6'd63,      8'h00, 1'b0, 1'b1, '{64'd1295, 16'd2, RADIX_MAX}},
		'{6'd1,       "0",   1'b1, 1'b0, '0},
		'{6'd1,       "0",   1'b0, 1'b0, '0},
		'{6'd1,       "1",   1'b0, 1'b1, '{64'd0, 16'd2, 6'd1}},
		'{RADIX_DEC,  "0",   1'b1, 1'b0, '0},
		'{RADIX_DEC,  "x",   1'b0, 1'b0, '0},
		'{RADIX_DEC,  "g",   1'b0, 1'b1, '{64'd0, 16'd2, RADIX_HEX}},
		'{RADIX_MAX,  "{",   1'b1, 1'b1, '{64'd0, 16'd0, RADIX_MAX}}
	};

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [5:0] digit_of(input logic [7:0] c);
		logic [7:0] l;
		l = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
		if (l >= "0" && l <= "9")
			return 6'(l - "0");
		if (l >= "a" && l <= "z")
			return 6'(l - "a" + 8'd10);
		return DIGIT_NONE;
	endfunction

	function automatic bit take_digit(input logic [7:0] c, output result_t r);
		logic [5:0] v;
		v = digit_of(c);
		r = '0;
		if (v < model_radix) begin
			model_acc = model_acc * model_radix + v;
			if (model_count != 16'hFFFF)
				model_count = model_count + 16'd1;
			model_phase = PH_DIGITS;
			return 1'b0;
		end
		r = '{model_acc, model_count, model_radix};
		model_phase = PH_IDLE;
		return 1'b1;
	endfunction

	function automatic bit parse_char(input item_t it, output result_t r);
		r = '0;
		if (it.first_char) begin
			model_acc = '0;
			model_count = '0;
			model_radix = (model_base > RADIX_MAX) ? RADIX_MAX : model_base;
			if (it.char_code == "0") begin
				model_count = 16'd1;
				model_phase = PH_ZERO;
				return 1'b0;
			end
			if (model_radix == RADIX_AUTO)
				model_radix = RADIX_DEC;
			return take_digit(it.char_code, r);
		end
		case (model_phase)
			PH_ZERO: begin
				if (it.char_code == "x" || it.char_code == "X") begin
					model_radix = RADIX_HEX;
					model_count = 16'd2;
					model_acc = '0;
					model_phase = PH_DIGITS;
					return 1'b0;
				end
				if (model_radix == RADIX_AUTO)
					model_radix = RADIX_OCT;
				return take_digit(it.char_code, r);
			end
			PH_DIGITS: begin
				return take_digit(it.char_code, r);
			end
			default: begin
				model_phase = PH_IDLE;
				return 1'b0;
			end
		endcase
	endfunction

	always @(posedge clk) begin
		result_t predicted;
		result_t want;
		bit      hit;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else if (arst_n) begin
			if (pop && !empty) begin
				pops_done++;
				if (pending_results.size() == 0) begin
					$error("unexpected result transfer: value %0h count %0d radix %0d",
						result.parsed_value, result.chars_consumed, result.radix_used);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (result.parsed_value !== want.parsed_value) begin
						$error("parsed_value: expected %0h, got %0h",
							want.parsed_value, result.parsed_value);
						mismatches++;
					end
					if (result.chars_consumed !== want.chars_consumed) begin
						$error("chars_consumed: expected %0d, got %0d",
							want.chars_consumed, result.chars_consumed);
						mismatches++;
					end
					if (result.radix_used !== want.radix_used) begin
						$error("radix_used: expected %0d, got %0d",
							want.radix_used, result.radix_used);
						mismatches++;
					end
				end
			end
			if (psel && penable && pready && pwrite && paddr == BASE_ADDR)
				model_base = pwdata[5:0];
			if (psel && penable && pready && !pwrite && prdata !== {26'd0, model_base}) begin
				$error("base_setting: expected %0d, got %0d", model_base, prdata);
				mismatches++;
			end
			if (push && !full) begin
				hit = parse_char(item, predicted);
				if (hit || typed_on)
					pending_results.push_back(typed_on ? typed_want : predicted);
			end
		end
	end

	always @(negedge clk) begin
		int unsigned pop_hold;
		int unsigned pop_seen;
		if (arst_n) begin
			if (pop_seen != pops_done) begin
				pop_seen = pops_done;
				pop_hold = calm ? 0 : $urandom_range(0, 12);
			end
			if (pop_hold != 0) begin
				pop <= 1'b0;
				pop_hold--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic send(input logic [7:0] ch, input logic first,
			input logic typed = 1'b0, input result_t want = '0);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		item <= '{char_code: ch, first_char: first};
		typed_on <= typed;
		typed_want <= want;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_base(input logic [5:0] b);
		logic [31:0] wd;
		wd = $urandom();
		wd[5:0] = b;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= BASE_ADDR;
		pwdata <= wd;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		cur_base = b;
	endtask

	function automatic logic [7:0] digit_char(input int unsigned rad);
		int unsigned v;
		v = $urandom_range(0, rad - 1);
		if (v < 10)
			return 8'("0" + v);
		return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
	endfunction

	task automatic random_string(inout int unsigned sent);
		int unsigned eff;
		int unsigned rad;
		int unsigned n;
		int unsigned sel;
		eff = (cur_base > RADIX_MAX) ? RADIX_MAX : cur_base;
		calm <= ($urandom_range(0, 7) == 0);
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			send(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
			sent++;
		end else begin
			rad = (eff == 0) ? 10 : eff;
			if (sel < 45) begin
				send("0", 1'b1);
				sent++;
				rad = (eff == 0) ? 8 : eff;
				if ($urandom_range(0, 1)) begin
					send($urandom_range(0, 1) ? "x" : "X", 1'b0);
					sent++;
					rad = 16;
				end
			end else if (sel < 55) begin
				send(8'($urandom_range(0, 255)), 1'b1);
				sent++;
			end else begin
				send(digit_char(rad), 1'b1);
				sent++;
			end
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
			repeat (n) begin
				send(digit_char(rad), 1'b0);
				sent++;
			end
			if ($urandom_range(0, 9) != 0) begin
				send(8'($urandom_range(0, 255)), 1'b0);
				sent++;
			end
		end
	endtask

	initial begin
		logic [5:0]  sweep [9];
		logic [5:0]  b;
		int unsigned sent;
		int unsigned mark;
		sweep = '{RADIX_AUTO, 6'd1, 6'd2, RADIX_OCT, RADIX_DEC, RADIX_HEX, RADIX_MAX,
			6'd37, 6'd63};
		sent = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].first_char && dir_rows[i].base != cur_base) begin
				settle();
				write_base(dir_rows[i].base);
			end
			send(dir_rows[i].ch, dir_rows[i].first_char, dir_rows[i].typed,
				dir_rows[i].want);
		end

		calm <= 1'b1;
		settle();
		write_base(RADIX_DEC);
		send("1", 1'b1);
		repeat (LONG_DIGITS)
			send(8'("0" + $urandom_range(0, 9)), 1'b0);
		send(";", 1'b0);
		calm <= 1'b0;

		for (int p = 0; p < 12; p++) begin
			b = (p < 9) ? sweep[p] : 6'($urandom_range(0, 63));
			settle();
			write_base(b);
			mark = sent;
			while (sent - mark < PHASE_ITEMS)
				random_string(sent);
		end

		settle();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
